FILE: hdl/error_code_led_blinker_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion helpers for the error code LED blinker
// Clocked, reset-gated implication macros used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ERROR_CODE_LED_BLINKER_UNIT_ASSERT_SVH
`define ERROR_CODE_LED_BLINKER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ECL_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ecl assertion failed: same-cycle check");

// Next-cycle implication.
`define ECL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ecl assertion failed: next-cycle check");

`endif

FILE: hdl/ecl_pkg.sv
// ----------------------------------------------------------------------------
// ecl_pkg
// Shared types and timing constants of the error code LED blinker.
// ----------------------------------------------------------------------------
`default_nettype none

package ecl_pkg;

    localparam logic [9:0]  LONG_MS      = 10'd250;
    localparam logic [9:0]  SHORT_ON_MS  = 10'd10;
    localparam logic [9:0]  SHORT_OFF_MS = 10'd240;
    localparam logic [9:0]  PAUSE_MS     = 10'd1000;
    localparam logic [2:0]  PHASE_THOU   = 3'd0;
    localparam logic [2:0]  PHASE_TENS   = 3'd2;
    localparam logic [2:0]  PHASE_PAUSE  = 3'd4;
    localparam logic [13:0] CODE_MAX     = 14'd9999;

    // Reciprocal multipliers: x/1000 = (x*8389)>>23 for x <= 9999,
    // x/100 = (x*41)>>12 for x <= 999, x/10 = (x*205)>>11 for x <= 99.
    localparam logic [13:0] RECIP_1000 = 14'd8389;
    localparam logic [5:0]  RECIP_100  = 6'd41;
    localparam logic [7:0]  RECIP_10   = 8'd205;

    // Digit weight tables (unused entries are zero).
    localparam logic [13:0] X1000 [16] = '{
        14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000, 14'd6000,
        14'd7000, 14'd8000, 14'd9000, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0
    };
    localparam logic [9:0] X100 [16] = '{
        10'd0, 10'd100, 10'd200, 10'd300, 10'd400, 10'd500, 10'd600,
        10'd700, 10'd800, 10'd900, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0
    };
    localparam logic [6:0] X10 [16] = '{
        7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60,
        7'd70, 7'd80, 7'd90, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };

    // Beat leaving the digit split pipeline.
    typedef struct packed {
        logic       start;
        logic       tick;
        logic [3:0] thou;
        logic [3:0] hund;
        logic [6:0] rem;
    } ecl_beat_t;

    // Segment loaded on phase entry.
    typedef struct packed {
        logic [2:0] phase;
        logic       lit;
        logic [4:0] pulses;
        logic [9:0] ms;
    } ecl_seg_t;

endpackage

`default_nettype wire

FILE: hdl/ecl_digit_split.sv
// ----------------------------------------------------------------------------
// ecl_digit_split
// Input register plus two stages that peel thousands and hundreds digits.
// ----------------------------------------------------------------------------
`default_nettype none

module ecl_digit_split
    import ecl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        adv,
    input  wire logic        in_valid,
    input  wire logic        in_start,
    input  wire logic [13:0] in_code,
    input  wire logic        in_tick,
    output logic             beat_valid,
    output ecl_beat_t        beat
);

    logic        s1_valid_reg, s1_start_reg, s1_tick_reg;
    logic [13:0] s1_code_reg;
    logic        s2_valid_reg, s2_start_reg, s2_tick_reg;
    logic [3:0]  s2_thou_reg;
    logic [9:0]  s2_rem_reg;
    logic        s3_valid_reg;
    ecl_beat_t   s3_reg;

    logic [13:0] code_sat;
    logic [27:0] prod_thou;
    logic [3:0]  thou_next;
    logic [13:0] rem1_full;
    logic [15:0] prod_hund;
    logic [3:0]  hund_next;
    logic [9:0]  rem2_full;

    always_comb begin
        code_sat  = (s1_code_reg > CODE_MAX) ? CODE_MAX : s1_code_reg;
        prod_thou = 28'(code_sat) * 28'(RECIP_1000);
        thou_next = prod_thou[26:23];
        rem1_full = code_sat - X1000[thou_next];
        prod_hund = 16'(s2_rem_reg) * 16'(RECIP_100);
        hund_next = prod_hund[15:12];
        rem2_full = s2_rem_reg - X100[hund_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_start_reg <= in_start;
            s1_tick_reg  <= in_tick;
            s1_code_reg  <= in_code;
            s2_start_reg <= s1_start_reg;
            s2_tick_reg  <= s1_tick_reg;
            s2_thou_reg  <= thou_next;
            s2_rem_reg   <= rem1_full[9:0];
            s3_reg.start <= s2_start_reg;
            s3_reg.tick  <= s2_tick_reg;
            s3_reg.thou  <= s2_thou_reg;
            s3_reg.hund  <= hund_next;
            s3_reg.rem   <= rem2_full[6:0];
        end
    end

    assign beat_valid = s3_valid_reg;
    assign beat       = s3_reg;

endmodule

`default_nettype wire

FILE: hdl/ecl_sequencer.sv
// ----------------------------------------------------------------------------
// ecl_sequencer
// Blink state machine and result register; finishes tens/units split.
// ----------------------------------------------------------------------------
`default_nettype none

module ecl_sequencer
    import ecl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       adv,
    input  wire logic       idle_level,
    input  wire logic       beat_valid,
    input  wire ecl_beat_t  beat,
    output logic            out_valid,
    output logic            out_led,
    output logic            out_running,
    output logic [2:0]      out_phase
);

    logic             active_reg, active_next;
    logic [2:0]       phase_reg, phase_next;
    logic [4:0]       pulses_reg, pulses_next;
    logic [9:0]       ms_reg, ms_next;
    logic             lit_reg, lit_next;
    logic [3:0][3:0]  digit_reg, digit_next;
    logic             out_valid_reg, led_reg, running_reg;
    logic [2:0]       out_phase_reg;

    logic [14:0]      prod_tens;
    logic [3:0]       tens;
    logic [6:0]       units_full;
    logic [3:0]       units;
    logic [9:0]       ms_dec;
    logic [4:0]       pulses_dec;
    logic [2:0]       phase_after;
    logic [3:0][3:0]  enter_digits;
    logic [2:0]       enter_first;
    logic             do_enter;
    ecl_seg_t         seg;

    // First phase at or after 'first' with a nonzero digit, else the pause.
    function automatic ecl_seg_t enter_phase(input logic [2:0] first,
                                             input logic [3:0][3:0] digits);
        ecl_seg_t s;
        s.phase  = PHASE_PAUSE;
        s.lit    = 1'b0;
        s.pulses = 5'd1;
        s.ms     = PAUSE_MS;
        for (int p = 3; p >= 0; p--) begin
            if ((3'(p) >= first) && (digits[p] != 4'd0)) begin
                s.phase  = 3'(p);
                s.lit    = 1'b1;
                s.pulses = {digits[p], 1'b0};
                s.ms     = (3'(p) == PHASE_THOU || 3'(p) == PHASE_TENS) ?
                           LONG_MS : SHORT_ON_MS;
            end
        end
        return s;
    endfunction

    always_comb begin
        prod_tens  = 15'(beat.rem) * 15'(RECIP_10);
        tens       = prod_tens[14:11];
        units_full = beat.rem - X10[tens];
        units      = (units_full[3:0] == 4'd0) ? 4'd10 : units_full[3:0];

        ms_dec      = (ms_reg != 10'd0) ? ms_reg - 10'd1 : 10'd0;
        pulses_dec  = (pulses_reg != 5'd0) ? pulses_reg - 5'd1 : 5'd0;
        phase_after = (phase_reg >= PHASE_PAUSE) ? PHASE_THOU : phase_reg + 3'd1;

        active_next = active_reg;
        phase_next  = phase_reg;
        pulses_next = pulses_reg;
        ms_next     = ms_reg;
        lit_next    = lit_reg;
        digit_next  = digit_reg;
        do_enter    = 1'b0;
        enter_first = PHASE_THOU;

        if (beat.start) begin
            digit_next  = {units, tens, beat.hund, beat.thou};
            active_next = 1'b1;
            do_enter    = 1'b1;
        end else if (beat.tick && active_reg) begin
            ms_next = ms_dec;
            if (ms_dec == 10'd0) begin
                pulses_next = pulses_dec;
                if (pulses_dec == 5'd0) begin
                    do_enter    = 1'b1;
                    enter_first = phase_after;
                end else begin
                    lit_next = ~lit_reg;
                    if (phase_reg == PHASE_THOU || phase_reg == PHASE_TENS) begin
                        ms_next = LONG_MS;
                    end else begin
                        ms_next = lit_reg ? SHORT_OFF_MS : SHORT_ON_MS;
                    end
                end
            end
        end

        enter_digits = digit_next;
        seg = enter_phase(enter_first, enter_digits);
        if (do_enter) begin
            phase_next  = seg.phase;
            lit_next    = seg.lit;
            pulses_next = seg.pulses;
            ms_next     = seg.ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            phase_reg     <= 3'd0;
            pulses_reg    <= 5'd0;
            ms_reg        <= 10'd0;
            lit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= beat_valid;
            if (beat_valid) begin
                active_reg <= active_next;
                phase_reg  <= phase_next;
                pulses_reg <= pulses_next;
                ms_reg     <= ms_next;
                lit_reg    <= lit_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && beat_valid) begin
            digit_reg     <= digit_next;
            led_reg       <= active_next ? (idle_level ^ lit_next) : idle_level;
            running_reg   <= active_next;
            out_phase_reg <= active_next ? phase_next : 3'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_led     = led_reg;
    assign out_running = running_reg;
    assign out_phase   = out_phase_reg;

endmodule

`default_nettype wire

FILE: hdl/error_code_led_blinker_unit.sv
// Throughput: one beat per cycle; the three-register digit split pipeline
// and the result register all advance together whenever the result is free.
// Reset: synchronous active-low aresetn clears the pipeline, the sequencer
// (idle, phase 0, LED dark) and idle_level; stored digits are left as is.
// ----------------------------------------------------------------------------
// error_code_led_blinker_unit
// Blinks a four-digit decimal error code on an LED, one ms tick per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module error_code_led_blinker_unit
    import ecl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: LED level while dark
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    // input beats
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_start_req,
    input  wire logic [13:0] s_code,
    input  wire logic        s_tick,
    // result beats
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_led,
    output logic             m_running,
    output logic [2:0]       m_phase
);

    logic      idle_level_reg;
    logic      adv;
    logic      beat_valid;
    ecl_beat_t beat;

    // Whole pipeline moves as one: it advances whenever the result register
    // is empty or its beat is being taken. Bubbles travel like beats.
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Idle level register; the user must write it only while nothing is in flight; the block leaves this to the user.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_level_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            idle_level_reg <= cfg_wr_data;
        end
    end

    // Input register, saturation, thousands and hundreds digits.
    ecl_digit_split u_split (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_valid),
        .in_start   (s_start_req),
        .in_code    (s_code),
        .in_tick    (s_tick),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    // Tens/units, blink state update and the result register.
    ecl_sequencer u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .idle_level  (idle_level_reg),
        .beat_valid  (beat_valid),
        .beat        (beat),
        .out_valid   (m_valid),
        .out_led     (m_led),
        .out_running (m_running),
        .out_phase   (m_phase)
    );

endmodule

`default_nettype wire

FILE: hdl/ecl_checker.sv
// ----------------------------------------------------------------------------
// ecl_checker
// Port-level checks of the blinker result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "error_code_led_blinker_unit_assert.svh"

module ecl_checker
    import ecl_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_led,
    input wire logic       m_running,
    input wire logic [2:0] m_phase
);

    logic [4:0] m_payload;

    assign m_payload = {m_led, m_running, m_phase};

    // stalled result beat holds
    `ECL_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))
    // phase code never beyond the pause
    `ECL_ASSERT_IMPL(a_phase_range, aclk, aresetn, m_valid, m_phase <= PHASE_PAUSE)
    // idle results report phase zero
    `ECL_ASSERT_IMPL(a_idle_phase, aclk, aresetn, m_valid && !m_running, m_phase == 3'd0)
    // once running, never back to idle without reset
    `ECL_ASSERT_NEXT(a_stay_running, aclk, aresetn, m_valid && m_running, !m_valid || m_running)

endmodule

bind error_code_led_blinker_unit ecl_checker u_checker (.*);

`default_nettype wire

FILE: bench/ecl_blink_checker.sv
// ----------------------------------------------------------------------------
// ecl_blink_checker
// Watches both channels of the error code LED blinker, predicts the LED level,
// run flag and phase of every result beat, and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module ecl_blink_checker
    import ecl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_start_req,
    input  wire logic [13:0] s_code,
    input  wire logic        s_tick,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_led,
    input  wire logic        m_running,
    input  wire logic [2:0]  m_phase,
    output int               mismatch_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_MAX = 40;

    typedef struct packed {
        logic       led;
        logic       running;
        logic [2:0] phase;
    } blink_out_t;

    blink_out_t expected_blinks [$];

    // predicted sequencer state
    logic       idle_lvl;
    logic       seq_active;
    logic [3:0] digit_q [4];
    logic [2:0] cur_phase;
    logic [4:0] segs_left;
    logic [9:0] seg_ms;
    logic       lit_q;
    int         result_num;

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_MAX)
            $display("[%0t] result %0d: %s", $realtime, result_num, msg);
        mismatch_count++;
    endtask

    function automatic logic [9:0] segment_len(input logic [2:0] p, input logic on);
        if (p >= PHASE_PAUSE)
            return PAUSE_MS;
        if (p == PHASE_THOU || p == PHASE_TENS)
            return LONG_MS;
        return on ? SHORT_ON_MS : SHORT_OFF_MS;
    endfunction

    // Zero digits in thousands, hundreds and tens are skipped.
    task automatic open_phase(input logic [2:0] first);
        logic [2:0] p;
        p = first;
        while (p < PHASE_PAUSE && digit_q[p[1:0]] == 4'd0)
            p = p + 3'd1;
        if (p >= PHASE_PAUSE) begin
            cur_phase = PHASE_PAUSE;
            lit_q     = 1'b0;
            segs_left = 5'd1;
            seg_ms    = PAUSE_MS;
        end else begin
            cur_phase = p;
            lit_q     = 1'b1;
            segs_left = {digit_q[p[1:0]], 1'b0};
            seg_ms    = segment_len(p, 1'b1);
        end
    endtask

    task automatic predict_blink(input logic st, input logic [13:0] cd, input logic tk,
                                 output blink_out_t r);
        int unsigned c;
        c = cd;
        if (st) begin
            if (c > CODE_MAX)
                c = CODE_MAX;
            digit_q[0] = 4'(c / 1000);
            digit_q[1] = 4'((c % 1000) / 100);
            digit_q[2] = 4'((c % 100) / 10);
            digit_q[3] = (c % 10 == 0) ? 4'd10 : 4'(c % 10);
            seq_active = 1'b1;
            open_phase(PHASE_THOU);
        end else if (tk && seq_active) begin
            if (seg_ms != 10'd0)
                seg_ms = seg_ms - 10'd1;
            if (seg_ms == 10'd0) begin
                if (segs_left != 5'd0)
                    segs_left = segs_left - 5'd1;
                if (segs_left == 5'd0) begin
                    if (cur_phase >= PHASE_PAUSE)
                        open_phase(PHASE_THOU);
                    else
                        open_phase(cur_phase + 3'd1);
                end else begin
                    lit_q  = ~lit_q;
                    seg_ms = segment_len(cur_phase, lit_q);
                end
            end
        end
        r.led     = seq_active ? (idle_lvl ^ lit_q) : idle_lvl;
        r.running = seq_active;
        r.phase   = seq_active ? cur_phase : 3'd0;
    endtask

    always @(posedge aclk) begin : monitor
        blink_out_t want;
        if (!aresetn) begin
            idle_lvl   = 1'b0;
            seq_active = 1'b0;
            foreach (digit_q[i])
                digit_q[i] = 4'd0;
            cur_phase  = 3'd0;
            segs_left  = 5'd0;
            seg_ms     = 10'd0;
            lit_q      = 1'b0;
            expected_blinks.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_blinks.size() == 0) begin
                    flag_mismatch("result beat with nothing pending");
                end else begin
                    want = expected_blinks.pop_front();
                    if (m_led !== want.led)
                        flag_mismatch($sformatf("led got %b expected %b", m_led, want.led));
                    if (m_running !== want.running)
                        flag_mismatch($sformatf("running got %b expected %b",
                                                m_running, want.running));
                    if (m_phase !== want.phase)
                        flag_mismatch($sformatf("phase got %0d expected %0d",
                                                m_phase, want.phase));
                end
                result_num++;
            end
            if (s_valid && s_ready) begin
                predict_blink(s_start_req, s_code, s_tick, want);
                expected_blinks.push_back(want);
            end
            // beats accepted on this edge still see the old level
            if (cfg_wr_en)
                idle_lvl = cfg_wr_data;
        end
        pending_count = expected_blinks.size();
    end

endmodule

`default_nettype wire

FILE: bench/error_code_led_blinker_unit_tb.sv
// ----------------------------------------------------------------------------
// error_code_led_blinker_unit_tb
// Drives start and tick beats into the LED blinker under random back-pressure
// and sender gaps, switches the idle level between phases, and reports the
// verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
`default_nettype none

module error_code_led_blinker_unit_tb
    import ecl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_start_req = 1'b0;
    logic [13:0] s_code      = 14'd0;
    logic        s_tick      = 1'b0;
    logic        m_ready     = 1'b0;
    wire logic   s_ready;
    wire logic   m_valid;
    wire logic   m_led;
    wire logic   m_running;
    wire logic [2:0] m_phase;

    int mismatch_count;
    int pending_count;

    // stimulus bookkeeping, shared with the result sink
    int beats_sent = 0;
    int beat_limit = 1_000_000;   // episodes are cut short here
    bit quiet_mode = 1'b0;   // no idling on either side
    bit closing    = 1'b0;   // last stretch of the run, no idling at all

    error_code_led_blinker_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_start_req (s_start_req),
        .s_code      (s_code),
        .s_tick      (s_tick),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_led       (m_led),
        .m_running   (m_running),
        .m_phase     (m_phase)
    );

    ecl_blink_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_req    (s_start_req),
        .s_code         (s_code),
        .s_tick         (s_tick),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_led          (m_led),
        .m_running      (m_running),
        .m_phase        (m_phase),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Offer one beat from the next falling edge and hold it until a rising
    // edge sees ready. Valid stays high if the next beat follows at once.
    task automatic send_beat(input logic st, input logic [13:0] cd, input logic tk);
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_start_req <= st;
        s_code      <= cd;
        s_tick      <= tk;
        do
            @(posedge aclk);
        while (!s_ready);
        beats_sent++;
    endtask

    // Drop valid for a gap set by n (n >= 1).
    task automatic sender_gap(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic maybe_idle();
        if (!quiet_mode && !closing && $urandom_range(0, 5) == 0)
            sender_gap($urandom_range(1, 14));
    endtask

    // Register writes only once every result beat is back, so the block
    // is idle on the channels when the level changes.
    task automatic write_idle_level(input logic lvl);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lvl;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One start beat and a run of tick beats behind it. Half the codes have
    // small digits so that the run gets through phases and into the pause;
    // a wrap run uses code 1 with a tick on every beat, long enough to come
    // back around to the start of the sequence.
    task automatic blink_episode(input bit wrap_run);
        logic [13:0] cd;
        int          pick;
        int          run_len;
        pick = $urandom_range(0, 9);
        if (wrap_run)
            cd = 14'd1;
        else if (pick == 0)
            cd = 14'($urandom_range(0, 16383));   // saturation and all code bits
        else if (pick <= 5)
            cd = 14'($urandom_range(0, 2) * 1000 + $urandom_range(0, 2) * 100
                     + $urandom_range(0, 2) * 10 + $urandom_range(0, 2));
        else
            cd = 14'($urandom_range(0, CODE_MAX));
        quiet_mode = wrap_run || ($urandom_range(0, 3) == 0);
        maybe_idle();
        send_beat(1'b1, cd, 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 19);
        if (wrap_run)
            run_len = 1600;
        else if (pick < 14)
            run_len = $urandom_range(0, 40);
        else if (pick < 19)
            run_len = $urandom_range(200, 600);
        else
            run_len = $urandom_range(1100, 3600);
        for (int i = 0; i < run_len && beats_sent < beat_limit; i++) begin
            if (beats_sent + 150 >= beat_limit)
                closing = 1'b1;
            maybe_idle();
            // code is noise here: it only matters on a start beat
            send_beat(1'b0, 14'($urandom_range(0, 16383)),
                      wrap_run || $urandom_range(0, 4) != 0);
        end
    endtask

    // Result sink: random stall bursts, one long hold-off while the sender
    // keeps offering beats so the pipeline fills and s_ready drops.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && beats_sent >= 200) begin
                hold_done = 1'b1;
                hold_left = 120;
            end
            if (closing) begin
                m_ready <= 1'b1;
            end else if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!quiet_mode && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 14);
            end
        end
    end

    initial begin : stimulus
        int base;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_idle_level(1'b1);

        // directed beats
        send_beat(1'b0, 14'd0, 1'b1);        // tick while idle: ignored
        send_beat(1'b0, 14'd16383, 1'b0);    // nothing while idle
        send_beat(1'b1, 14'd0, 1'b0);        // zero units: ten short blinks
        send_beat(1'b0, 14'd0, 1'b1);
        send_beat(1'b0, 14'd0, 1'b0);
        send_beat(1'b1, 14'd9999, 1'b1);     // tick on a start beat is ignored
        send_beat(1'b0, 14'd0, 1'b1);
        send_beat(1'b1, 14'd16383, 1'b0);    // top code, saturates
        send_beat(1'b1, 14'd10000, 1'b1);    // just past the top
        send_beat(1'b1, 14'd1010, 1'b0);     // restart while running, zero hundreds
        send_beat(1'b0, 14'd0, 1'b1);
        send_beat(1'b1, 14'd1, 1'b0);        // leading zeros skip straight to units
        repeat (11) send_beat(1'b0, 14'd0, 1'b1);   // short lit segment ends

        write_idle_level(1'b0);
        base = beats_sent;
        beat_limit = base + 1950;
        blink_episode(1'b1);
        while (beats_sent < base + 900)
            blink_episode(1'b0);

        write_idle_level(1'b1);
        while (beats_sent < base + 1400)
            blink_episode(1'b0);

        write_idle_level(1'($urandom_range(0, 1)));
        while (beats_sent < beat_limit) begin
            if (beats_sent >= base + 1800)
                closing = 1'b1;
            blink_episode(1'b0);
        end
        closing = 1'b1;

        // drain, then wait out anything stray
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("PASS error_code_led_blinker_unit");
        else
            $display("FAIL error_code_led_blinker_unit");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("FAIL error_code_led_blinker_unit");
        $finish;
    end

endmodule

`default_nettype wire

FILE: error_code_led_blinker_unit.f
+incdir+hdl
hdl/ecl_pkg.sv
hdl/ecl_digit_split.sv
hdl/ecl_sequencer.sv
hdl/error_code_led_blinker_unit.sv
hdl/ecl_checker.sv
bench/ecl_blink_checker.sv
bench/error_code_led_blinker_unit_tb.sv
